>>> rtl/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg
// shared constants and types for the aging page replacement block
// ----------------------------------------------------------------------------
package apr_pkg;

  localparam int DEF_MAX_FRAMES = 16;
  localparam int DEF_AGE_BITS   = 16;

  localparam int PAGE_W    = 16;
  localparam int CFG_W     = 5;
  localparam int IDX_OUT_W = 4;
  localparam int TOTAL_W   = 32;

  // widest frame number and counter over the parameter ranges
  localparam int MAX_IDX_W = 6;
  localparam int MAX_AGE_W = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  // running search result passed from cell to cell
  typedef struct packed {
    logic                 has;
    logic                 found;
    logic [MAX_IDX_W-1:0] found_idx;
    logic [MAX_AGE_W-1:0] best_age;
    logic [MAX_IDX_W-1:0] best_idx;
    logic                 best_valid;
    logic [PAGE_W-1:0]    best_page;
  } carry_t;

  // update broadcast to every cell at the end of a search
  typedef struct packed {
    logic                 en;
    logic [MAX_IDX_W-1:0] slot;
    logic                 refill;
    logic [PAGE_W-1:0]    page;
  } upd_t;

endpackage

>>> rtl/apr_if.sv
// ----------------------------------------------------------------------------
// apr channel interfaces
// valid/ready channels for page references and replacement results
// ----------------------------------------------------------------------------
interface apr_in_if import apr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_id;

  modport source (output valid, output page_id, input ready);
  modport sink   (input valid, input page_id, output ready);
endinterface

interface apr_out_if import apr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [IDX_OUT_W-1:0] frame_index;
  logic                 evicted_valid;
  logic [PAGE_W-1:0]    evicted_page;
  logic [TOTAL_W-1:0]   hit_total;
  logic [TOTAL_W-1:0]   miss_total;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output hit_total, output miss_total, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input hit_total, input miss_total, output ready);
endinterface

>>> rtl/aging_page_replacement.sv
// ----------------------------------------------------------------------------
// aging_page_replacement
// page frame table with aging counters, hit search and least-aged victim
// ----------------------------------------------------------------------------
//
//  port     dir   handshake          carries
//  in_ch    in    valid/ready        page_id
//  out_ch   out   valid/ready        hit, frame_index, evicted_*, hit/miss totals
//  cfg_*    in    cfg_we             active_frames
//
//  the search result walks one frame cell per cycle down the chain, so the
//  chain length sets how long each item takes
//  the result sits in an output register, so the next item is taken while
//  it waits; a full output register holds the finished search until taken
//  reset (synchronous, rst_n low) clears all frames to invalid, all counters
//  and totals to zero, and active_frames to 16
//
module aging_page_replacement import apr_pkg::*; #(
  parameter int MAX_FRAMES = DEF_MAX_FRAMES,
  parameter int AGE_BITS   = DEF_AGE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  apr_in_if.sink           in_ch,
  apr_out_if.source        out_ch
);

  localparam int N_W = $clog2(MAX_FRAMES + 1);

  // control states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state_r, state_nxt;
  logic [N_W-1:0]    cnt_r, cnt_nxt;
  logic [PAGE_W-1:0] key_r, key_nxt;
  logic [CFG_W-1:0]  cfg_r;
  logic [N_W-1:0]    n_eff;
  logic [MAX_FRAMES-1:0] active;

  logic [TOTAL_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [TOTAL_W-1:0] miss_cnt_r, miss_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic                 out_ev_valid_r;
  logic [PAGE_W-1:0]    out_ev_page_r;

  logic   accept, out_free, fin;
  carry_t chain [MAX_FRAMES+1];
  carry_t last;
  upd_t   upd;
  logic [MAX_IDX_W-1:0] slot;

  // frames in use: zero counts as one, above the table size saturates
  always_comb begin
    if (cfg_r == '0)
      n_eff = N_W'(1);
    else if (int'(cfg_r) > MAX_FRAMES)
      n_eff = N_W'(MAX_FRAMES);
    else
      n_eff = N_W'(cfg_r);
  end

  // chain of frame cells, the search enters at frame 0
  assign chain[0] = '0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    assign active[g] = (N_W'(g) < n_eff);
    apr_cell #(
      .LANE     (g),
      .AGE_BITS (AGE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .active  (active[g]),
      .key     (key_r),
      .carry_i (chain[g]),
      .upd     (upd),
      .carry_o (chain[g+1])
    );
  end

  assign last     = chain[MAX_FRAMES];
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  // last cell has seen the whole table once the count reaches the length
  assign fin      = (state_r == S_SCAN) && (cnt_r == N_W'(MAX_FRAMES)) && out_free;
  assign slot     = last.found ? last.found_idx : last.best_idx;

  always_comb begin
    upd.en     = fin;
    upd.slot   = slot;
    upd.refill = !last.found;
    upd.page   = key_r;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    key_nxt      = key_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt   = in_ch.page_id;
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r != N_W'(MAX_FRAMES))
          cnt_nxt = cnt_r + N_W'(1);
        if (fin) begin
          state_nxt = S_IDLE;
          // saturating totals
          if (last.found && hit_cnt_r != '1)
            hit_cnt_nxt = hit_cnt_r + TOTAL_W'(1);
          if (!last.found && miss_cnt_r != '1)
            miss_cnt_nxt = miss_cnt_r + TOTAL_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready)
      out_valid_nxt = 1'b0;
    if (fin)
      out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cfg_r       <= CFG_RESET;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we)
        cfg_r <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (fin) begin
      out_hit_r      <= last.found;
      out_idx_r      <= slot[IDX_OUT_W-1:0];
      out_ev_valid_r <= !last.found && last.best_valid;
      out_ev_page_r  <= (!last.found && last.best_valid) ? last.best_page : '0;
    end
  end

  // no item is taken while reset is held
  assign in_ch.ready          = rst_n && (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.frame_index   = out_idx_r;
  assign out_ch.evicted_valid = out_ev_valid_r;
  assign out_ch.evicted_page  = out_ev_page_r;
  assign out_ch.hit_total     = hit_cnt_r;
  assign out_ch.miss_total    = miss_cnt_r;

  // a finished search always leaves a result waiting
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid_r)
    else $error("finished search left no result");

  // the chosen frame lies inside the frames in use
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> (int'(slot) < int'(n_eff)))
    else $error("frame outside the active range chosen");

  // a hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> !out_ev_valid_r)
    else $error("eviction reported on a hit");

  // exactly one total moves per finished item unless saturated
  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && hit_cnt_r != '1 && miss_cnt_r != '1) |=>
      ((hit_cnt_r != $past(hit_cnt_r)) != (miss_cnt_r != $past(miss_cnt_r))))
    else $error("totals did not advance by one item");

endmodule

>>> rtl/apr_cell.sv
// ----------------------------------------------------------------------------
// apr_cell
// one page frame: holds page, valid mark and aging counter, extends the search
// ----------------------------------------------------------------------------
module apr_cell import apr_pkg::*; #(
  parameter int LANE     = 0,
  parameter int AGE_BITS = DEF_AGE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              active,
  input  logic [PAGE_W-1:0] key,
  input  carry_t            carry_i,
  input  upd_t              upd,
  output carry_t            carry_o
);

  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic                valid_r, valid_nxt;
  logic [AGE_BITS-1:0] age_r, age_nxt;
  carry_t              carry_r, carry_nxt;
  logic                hit_here, take, is_slot;
  logic [MAX_AGE_W-1:0] my_age;

  assign my_age   = MAX_AGE_W'(age_r);
  assign hit_here = valid_r && (page_r == key);
  assign take     = !carry_i.has || (my_age < carry_i.best_age);
  assign is_slot  = (upd.slot == MAX_IDX_W'(LANE));

  always_comb begin
    carry_nxt = carry_i;
    if (active) begin
      carry_nxt.has = 1'b1;
      if (!carry_i.found && hit_here) begin
        carry_nxt.found     = 1'b1;
        carry_nxt.found_idx = MAX_IDX_W'(LANE);
      end
      if (take) begin
        carry_nxt.best_age   = my_age;
        carry_nxt.best_idx   = MAX_IDX_W'(LANE);
        carry_nxt.best_valid = valid_r;
        carry_nxt.best_page  = page_r;
      end
    end
  end

  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    age_nxt   = age_r;
    if (upd.en && active) begin
      // shift right, referenced frame takes the top bit
      age_nxt = {is_slot, age_r[AGE_BITS-1:1]};
      if (is_slot && upd.refill) begin
        page_nxt  = upd.page;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r  <= '0;
      valid_r <= 1'b0;
      age_r   <= '0;
      carry_r <= '0;
    end else begin
      page_r  <= page_nxt;
      valid_r <= valid_nxt;
      age_r   <= age_nxt;
      carry_r <= carry_nxt;
    end
  end

  assign carry_o = carry_r;

endmodule
